[sv/dot_grid_bar_pixel_generator_assert.svh]
// Assertion macros for the dot grid bar pixel generator.
`ifndef DOT_GRID_BAR_PIXEL_GENERATOR_ASSERT_SVH
`define DOT_GRID_BAR_PIXEL_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define DGB_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dot grid bar pixel generator check failed");
// Check that cons holds in the cycle after ante.
`define DGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dot grid bar pixel generator check failed");
`else
`define DGB_ASSERT_IMPLIES(label, ante, cons)
`define DGB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/dgb_pkg.sv]
// Types and constants shared by the dot grid bar pixel generator.
package dgb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_DOT    = 16;

    // Register stages ahead of the output register
    localparam int NUM_STAGES = 9;
    // Cycles from accepted start to result strobe
    localparam int LATENCY    = NUM_STAGES + 1;

    localparam int WR_DATA_W  = 24;

    localparam logic [1:0] DOT_SQUARE = 2'd1;
    localparam logic [1:0] DOT_ROUND  = 2'd2;

    typedef enum logic [2:0] {
        REG_BAR_WIDTH     = 3'd0,
        REG_BAR_HEIGHT    = 3'd1,
        REG_DOT_STYLE     = 3'd2,
        REG_DOT_SIZE      = 3'd3,
        REG_DOT_GAP       = 3'd4,
        REG_FILLED_EXTENT = 3'd5,
        REG_TRACK_RGB     = 3'd6,
        REG_FILL_RGB      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [5:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [31:0] argb_value;
        logic        config_ok;
    } result_t;

endpackage

[sv/dot_grid_bar_pixel_generator.sv]
// Dot grid progress bar pixel generator built as a pixel pipeline.
//
// Pixel pipeline: one pixel request may be issued on every clock (busy stays
// low), and each result appears with a one-cycle valid strobe once it has
// passed the stage registers and the output register, in request order.
// The receiver cannot stall the output, so nothing is held back. The pipeline
// holds two chained ten-step divisions by the grid pitch (grid size, then dot
// position within the grid), five steps in each of two stages per division,
// then the subsample circle test over squaring, compare and count stages.
// Registers are written through the wr_en / wr_index / wr_data port and take
// effect for pixels started afterwards; write them only while no pixel is in
// flight. The track and fill colours are instead read at the output stage.
module dot_grid_bar_pixel_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dgb_pkg::pixel_t               pixel,
    output logic                          valid,
    output dgb_pkg::result_t              result,
    input  logic                          wr_en,
    input  dgb_pkg::reg_idx_t             wr_index,
    input  logic [dgb_pkg::WR_DATA_W-1:0] wr_data
);
    import dgb_pkg::*;

    // Restoring divider state: remainder and dividend/quotient shift word
    typedef struct packed {
        logic [5:0] rem;
        logic [9:0] quo;
    } div_t;

    typedef struct packed {
        logic             ok;
        logic             blank;
        logic             round;
        logic             fill;
        logic [7:0]       px;
        logic [5:0]       py;
        logic [4:0]       dot_edge;
        logic [5:0]       pitch;
        logic [13:0]      lim;
        div_t             cdiv;
        div_t             rdiv;
        logic [9:0]       cols;
        logic [9:0]       rows;
        logic [3:0][6:0]  dxm;
        logic [3:0][6:0]  dym;
        logic [3:0][13:0] sqx;
        logic [3:0][13:0] sqy;
        logic [15:0]      hits;
    } pix_t;

    // One restoring division step by the pitch
    function automatic div_t div_step(input div_t d, input logic [5:0] pitch);
        logic [6:0] t;
        div_t       r;
        t = {d.rem, d.quo[9]};
        if (t >= {1'b0, pitch})
        begin
            r.rem = 6'(t - {1'b0, pitch});
            r.quo = {d.quo[8:0], 1'b1};
        end
        else
        begin
            r.rem = t[5:0];
            r.quo = {d.quo[8:0], 1'b0};
        end
        return r;
    endfunction

    logic [8:0]  bar_width_reg;
    logic [6:0]  bar_height_reg;
    logic [1:0]  dot_style_reg;
    logic [4:0]  dot_size_reg;
    logic [3:0]  dot_gap_reg;
    logic [8:0]  filled_extent_reg;
    logic [23:0] track_rgb_reg;
    logic [23:0] fill_rgb_reg;

    logic                  accept;
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    pix_t                  pipe_reg  [NUM_STAGES];
    pix_t                  pipe_next [NUM_STAGES];
    logic                  valid_reg;
    result_t               result_reg;
    result_t               result_next;

    // Pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign valid  = valid_reg;
    assign result = result_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_width_reg     <= 9'd128;
            bar_height_reg    <= 7'd16;
            dot_style_reg     <= DOT_SQUARE;
            dot_size_reg      <= 5'd4;
            dot_gap_reg       <= 4'd1;
            filled_extent_reg <= 9'd0;
            track_rgb_reg     <= 24'd0;
            fill_rgb_reg      <= 24'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BAR_WIDTH:     bar_width_reg     <= wr_data[8:0];
                REG_BAR_HEIGHT:    bar_height_reg    <= wr_data[6:0];
                REG_DOT_STYLE:     dot_style_reg     <= wr_data[1:0];
                REG_DOT_SIZE:      dot_size_reg      <= wr_data[4:0];
                REG_DOT_GAP:       dot_gap_reg       <= wr_data[3:0];
                REG_FILLED_EXTENT: filled_extent_reg <= wr_data[8:0];
                REG_TRACK_RGB:     track_rgb_reg     <= wr_data[23:0];
                REG_FILL_RGB:      fill_rgb_reg      <= wr_data[23:0];
            endcase
        end
    end

    // Stage logic
    always_comb
    begin
        logic       ok;
        logic [4:0] dot_edge;
        logic [9:0] csq;
        logic [4:0] x0;
        logic [4:0] y0;
        logic [7:0] rx;
        logic [5:0] ry;
        logic [10:0] dv;
        logic [14:0] ssum;
        logic [4:0]  hcnt;
        logic [12:0] ascaled;
        logic [7:0]  alpha;
        logic [23:0] rgb;
        pix_t        p;

        // Stage 1: configuration check, dot edge and pitch, divider setup
        dot_edge = (dot_size_reg < 5'(bar_height_reg) && bar_height_reg < 7'd32) ?
                   dot_size_reg :
                   ((bar_height_reg < 7'd32) ? bar_height_reg[4:0] : dot_size_reg);
        ok = bar_width_reg >= 9'd1 && bar_width_reg <= 9'(MAX_WIDTH) &&
             bar_height_reg >= 7'd2 && bar_height_reg <= 7'(MAX_HEIGHT) &&
             (dot_style_reg == DOT_SQUARE || dot_style_reg == DOT_ROUND) &&
             dot_size_reg >= 5'd2 && dot_size_reg <= 5'(MAX_DOT) &&
             dot_gap_reg <= 4'd8 && filled_extent_reg <= bar_width_reg &&
             {4'd0, dot_edge} <= bar_width_reg;
        csq = {5'd0, dot_edge} * {5'd0, dot_edge};
        p = pipe_reg[0];
        p.ok       = ok;
        p.blank    = !ok || {1'b0, pixel.pixel_x} >= bar_width_reg ||
                     {1'b0, pixel.pixel_y} >= bar_height_reg;
        p.round    = dot_style_reg == DOT_ROUND;
        p.fill     = {1'b0, pixel.pixel_x} < filled_extent_reg;
        p.px       = pixel.pixel_x;
        p.py       = pixel.pixel_y;
        p.dot_edge = dot_edge;
        p.pitch    = {1'b0, dot_edge} + {2'b0, dot_gap_reg};
        p.lim      = {csq, 4'b0};
        p.cdiv.rem = '0;
        p.cdiv.quo = {1'b0, bar_width_reg} + {6'd0, dot_gap_reg};
        p.rdiv.rem = '0;
        p.rdiv.quo = {3'd0, bar_height_reg} + {6'd0, dot_gap_reg};
        pipe_next[0] = p;

        // Stage 2: first half of the grid size division
        p = pipe_reg[0];
        for (int i = 0; i < 5; i++)
        begin
            p.cdiv = div_step(p.cdiv, p.pitch);
            p.rdiv = div_step(p.rdiv, p.pitch);
        end
        pipe_next[1] = p;

        // Stage 3: second half, keep column and row counts
        p = pipe_reg[1];
        for (int i = 0; i < 5; i++)
        begin
            p.cdiv = div_step(p.cdiv, p.pitch);
            p.rdiv = div_step(p.rdiv, p.pitch);
        end
        p.cols = p.cdiv.quo;
        p.rows = p.rdiv.quo;
        pipe_next[2] = p;

        // Stage 4: centre the grid, set up the position division
        p = pipe_reg[2];
        x0 = p.cdiv.rem[5:1];
        y0 = p.rdiv.rem[5:1];
        rx = p.px - {3'd0, x0};
        ry = p.py - {1'd0, y0};
        if (p.px < {3'd0, x0} || p.py < {1'd0, y0})
        begin
            p.blank = 1'b1;
        end
        p.cdiv.rem = '0;
        p.cdiv.quo = {2'd0, rx};
        p.rdiv.rem = '0;
        p.rdiv.quo = {4'd0, ry};
        pipe_next[3] = p;

        // Stage 5: first half of the position division
        p = pipe_reg[3];
        for (int i = 0; i < 5; i++)
        begin
            p.cdiv = div_step(p.cdiv, p.pitch);
            p.rdiv = div_step(p.rdiv, p.pitch);
        end
        pipe_next[4] = p;

        // Stage 6: second half of the position division
        p = pipe_reg[4];
        for (int i = 0; i < 5; i++)
        begin
            p.cdiv = div_step(p.cdiv, p.pitch);
            p.rdiv = div_step(p.rdiv, p.pitch);
        end
        pipe_next[5] = p;

        // Stage 7: drop pixels off the grid or in a gap, form sample offsets
        p = pipe_reg[5];
        if (p.cdiv.quo >= p.cols || p.rdiv.quo >= p.rows ||
            p.cdiv.rem >= {1'b0, p.dot_edge} || p.rdiv.rem >= {1'b0, p.dot_edge})
        begin
            p.blank = 1'b1;
        end
        for (int i = 0; i < 4; i++)
        begin
            dv = {2'd0, p.cdiv.rem, 3'd0} + 11'(2 * i + 1) - {4'd0, p.dot_edge, 2'd0};
            p.dxm[i] = dv[10] ? 7'(-dv) : dv[6:0];
            dv = {2'd0, p.rdiv.rem, 3'd0} + 11'(2 * i + 1) - {4'd0, p.dot_edge, 2'd0};
            p.dym[i] = dv[10] ? 7'(-dv) : dv[6:0];
        end
        pipe_next[6] = p;

        // Stage 8: square the offsets
        p = pipe_reg[6];
        for (int i = 0; i < 4; i++)
        begin
            p.sqx[i] = p.dxm[i] * p.dxm[i];
            p.sqy[i] = p.dym[i] * p.dym[i];
        end
        pipe_next[7] = p;

        // Stage 9: circle test for all sixteen samples
        p = pipe_reg[7];
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ssum = {1'b0, p.sqx[i]} + {1'b0, p.sqy[j]};
                p.hits[j * 4 + i] = ssum <= {1'b0, p.lim};
            end
        end
        pipe_next[8] = p;

        // Output: coverage to alpha, colour select
        p = pipe_reg[8];
        hcnt    = 5'($countones(p.hits));
        ascaled = {hcnt, 8'd0} - {8'd0, hcnt} + 13'd8;
        alpha   = p.round ? ascaled[11:4] : 8'd255;
        rgb     = p.fill ? fill_rgb_reg : track_rgb_reg;
        result_next.config_ok  = p.ok;
        result_next.argb_value = (p.blank || alpha == 8'd0) ? 32'd0 : {alpha, rgb};
    end

    // Advance valid bits
    assign vld_next = {vld_reg[NUM_STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            valid_reg <= vld_reg[NUM_STAGES-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            pipe_reg[k] <= pipe_next[k];
        end
        result_reg <= result_next;
    end

`include "dot_grid_bar_pixel_generator_assert.svh"

    `DGB_ASSERT_IMPLIES(a_result_latency, accept, ##LATENCY valid)
    `DGB_ASSERT_IMPLIES(a_no_spurious_result, valid, $past(accept, LATENCY))
    `DGB_ASSERT_IMPLIES(a_bad_config_blank, valid && !result.config_ok, result.argb_value == 32'd0)
    `DGB_ASSERT_IMPLIES(a_colour_has_alpha, valid && result.argb_value != 32'd0, result.argb_value[31:24] != 8'd0)

endmodule

[sim/dot_grid_bar_pixel_generator_test.sv]
// Self-checking testbench for the dot grid bar pixel generator.
module dot_grid_bar_pixel_generator_test;
    import dgb_pkg::*;

    localparam int MAX_GAP  = 8;
    localparam int OPAQUE   = 255;
    localparam int N_PIXELS = 850;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic                 busy;
    pixel_t               pixel    = '0;
    logic                 valid;
    result_t              result;
    logic                 wr_en    = 1'b0;
    reg_idx_t             wr_index = REG_BAR_WIDTH;
    logic [WR_DATA_W-1:0] wr_data  = '0;

    // Register copy, reset values match the block
    logic [8:0]  cfg_width  = 9'd128;
    logic [6:0]  cfg_height = 7'd16;
    logic [1:0]  cfg_style  = DOT_SQUARE;
    logic [4:0]  cfg_size   = 5'd4;
    logic [3:0]  cfg_gap    = 4'd1;
    logic [8:0]  cfg_extent = 9'd0;
    logic [23:0] cfg_track  = 24'd0;
    logic [23:0] cfg_fill   = 24'd0;

    pixel_t  pixel_requests[$];
    result_t argb_due[$];
    int      mismatch_count = 0;
    int      burst_left = 1;
    int      gap_left = 0;

    dot_grid_bar_pixel_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel    (pixel),
        .valid    (valid),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #4 clk = ~clk;

    // Compute the expected pixel from the register copy
    function automatic result_t render_pixel(input pixel_t p);
        int px, py, dot_edge, pitch, cols, rows, x0, y0, rx, ry, ox, oy;
        int hits, alpha, dx, dy;
        logic ok;
        result_t r;
        px = p.pixel_x;
        py = p.pixel_y;
        ok = cfg_width >= 1 && cfg_width <= MAX_WIDTH &&
             cfg_height >= 2 && cfg_height <= MAX_HEIGHT &&
             (cfg_style == DOT_SQUARE || cfg_style == DOT_ROUND) &&
             cfg_size >= 2 && cfg_size <= MAX_DOT &&
             cfg_gap <= MAX_GAP && cfg_extent <= cfg_width;
        dot_edge = (cfg_size < cfg_height) ? cfg_size : cfg_height;
        if (dot_edge > cfg_width)
            ok = 1'b0;
        r.argb_value = '0;
        r.config_ok  = ok;
        if (!ok || px >= cfg_width || py >= cfg_height)
            return r;

        // Place the centered grid and locate the pixel inside its cell
        pitch = dot_edge + cfg_gap;
        cols  = (cfg_width + cfg_gap) / pitch;
        rows  = (cfg_height + cfg_gap) / pitch;
        x0    = (cfg_width - (cols * pitch - cfg_gap)) / 2;
        y0    = (cfg_height - (rows * pitch - cfg_gap)) / 2;
        if (px < x0 || py < y0)
            return r;
        rx = px - x0;
        ry = py - y0;
        if (rx / pitch >= cols || ry / pitch >= rows)
            return r;
        ox = rx % pitch;
        oy = ry % pitch;
        if (ox >= dot_edge || oy >= dot_edge)
            return r;

        // Count 4x4 subsamples inside the inscribed circle for round dots
        if (cfg_style == DOT_ROUND)
        begin
            hits = 0;
            for (int sy = 1; sy < 8; sy += 2)
            begin
                for (int sx = 1; sx < 8; sx += 2)
                begin
                    dx = ox * 8 + sx - dot_edge * 4;
                    dy = oy * 8 + sy - dot_edge * 4;
                    if (dx * dx + dy * dy <= dot_edge * dot_edge * 16)
                        hits++;
                end
            end
            alpha = (hits * OPAQUE + 8) / 16;
        end
        else
            alpha = OPAQUE;
        if (alpha == 0)
            return r;
        r.argb_value[31:24] = 8'(alpha);
        r.argb_value[23:0]  = (px < cfg_extent) ? cfg_fill : cfg_track;
        return r;
    endfunction

    // Pick a pixel, mostly inside the bar, sometimes anywhere
    function automatic pixel_t pick_pixel();
        int x_span, y_span;
        pixel_t p;
        x_span = (cfg_width == 0 || cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        y_span = (cfg_height == 0 || cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        if ($urandom_range(0, 4) == 0)
        begin
            p.pixel_x = 8'($urandom);
            p.pixel_y = 6'($urandom);
        end
        else
        begin
            p.pixel_x = 8'($urandom_range(0, x_span - 1));
            p.pixel_y = 6'($urandom_range(0, y_span - 1));
        end
        return p;
    endfunction

    task automatic request(input int x, input int y);
        pixel_t p;
        p.pixel_x = 8'(x);
        p.pixel_y = 6'(y);
        pixel_requests.push_back(p);
    endtask

    // Hold until every queued pixel has been sent and answered
    task automatic wait_bar_idle();
        do
            @(negedge clk);
        while (pixel_requests.size() != 0 || start || argb_due.size() != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [WR_DATA_W-1:0] value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        case (idx)
            REG_BAR_WIDTH:     cfg_width  = value[8:0];
            REG_BAR_HEIGHT:    cfg_height = value[6:0];
            REG_DOT_STYLE:     cfg_style  = value[1:0];
            REG_DOT_SIZE:      cfg_size   = value[4:0];
            REG_DOT_GAP:       cfg_gap    = value[3:0];
            REG_FILLED_EXTENT: cfg_extent = value[8:0];
            REG_TRACK_RGB:     cfg_track  = value[23:0];
            REG_FILL_RGB:      cfg_fill   = value[23:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Drain, then load a whole bar setup
    task automatic set_bar(input int w, h, style, size, gap, extent, track, fill);
        wait_bar_idle();
        write_reg(REG_BAR_WIDTH, 24'(w));
        write_reg(REG_BAR_HEIGHT, 24'(h));
        write_reg(REG_DOT_STYLE, 24'(style));
        write_reg(REG_DOT_SIZE, 24'(size));
        write_reg(REG_DOT_GAP, 24'(gap));
        write_reg(REG_FILLED_EXTENT, 24'(extent));
        write_reg(REG_TRACK_RGB, 24'(track));
        write_reg(REG_FILL_RGB, 24'(fill));
    endtask

    task automatic random_bar();
        int w;
        if ($urandom_range(0, 9) == 0)
            set_bar($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 3),
                    $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 511),
                    $urandom, $urandom);
        else
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(41, 256);
            set_bar(w, $urandom_range(2, MAX_HEIGHT), $urandom_range(1, 2),
                    $urandom_range(2, MAX_DOT), $urandom_range(0, MAX_GAP),
                    $urandom_range(0, w), $urandom, $urandom);
        end
    endtask

    // Sender: issue pixels in bursts with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                argb_due.push_back(render_pixel(pixel));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pixel_requests.size() != 0)
                begin
                    pixel <= pixel_requests.pop_front();
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Receiver: compare each transfer with the oldest expected pixel
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && valid)
        begin
            if (argb_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: argb %h ok %b",
                             result.argb_value, result.config_ok);
            end
            else
            begin
                want = argb_due.pop_front();
                if (result.argb_value !== want.argb_value ||
                    result.config_ok !== want.config_ok)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pixel mismatch: expected argb %h ok %b, got argb %h ok %b",
                                 want.argb_value, want.config_ok,
                                 result.argb_value, result.config_ok);
                end
            end
        end
    end

    initial
    begin
        int phase;
        int total;
        int count;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setup: margin, first dot, gap, beyond the bar
        request(0, 0);
        request(2, 1);
        request(6, 1);
        request(255, 63);

        // Largest round dots: corners with zero coverage, edge, fill and track
        set_bar(256, 64, DOT_ROUND, 16, 8, 128, 24'h00ff00, 24'hff00ff);
        request(0, 0);
        request(7, 0);
        request(8, 8);
        request(130, 8);
        request(255, 63);

        // Smallest valid bar, then a dot clipped by the bar height
        set_bar(2, 2, DOT_SQUARE, 2, 0, 2, 24'hffffff, 24'hffffff);
        request(1, 1);
        request(2, 0);
        set_bar(40, 3, DOT_SQUARE, 16, 2, 0, 24'h123456, 24'h654321);
        request(20, 1);

        // Each way the setup can be rejected
        set_bar(128, 16, 0, 4, 1, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(128, 16, 3, 4, 1, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(128, 16, DOT_SQUARE, 1, 1, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(128, 16, DOT_SQUARE, 17, 1, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(0, 16, DOT_SQUARE, 4, 1, 0, 24'h111111, 24'h222222);
        request(0, 0);
        set_bar(257, 16, DOT_SQUARE, 4, 1, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(128, 1, DOT_SQUARE, 4, 1, 0, 24'h111111, 24'h222222);
        request(2, 0);
        set_bar(128, 65, DOT_SQUARE, 4, 1, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(128, 16, DOT_SQUARE, 4, 9, 0, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(128, 16, DOT_SQUARE, 4, 1, 129, 24'h111111, 24'h222222);
        request(2, 1);
        set_bar(3, 16, DOT_SQUARE, 4, 1, 0, 24'h111111, 24'h222222);
        request(0, 0);

        // Random phases, extremes first; some pause mid-phase until drained
        total = 0;
        phase = 0;
        while (total < N_PIXELS)
        begin
            if (phase == 0)
                set_bar(256, 64, DOT_ROUND, 16, 8, $urandom_range(0, 256), $urandom, $urandom);
            else if (phase == 1)
                set_bar(2, 2, DOT_SQUARE, 2, 0, $urandom_range(0, 2), $urandom, $urandom);
            else if (phase == 2)
                set_bar(256, 64, DOT_ROUND, 2, 0, $urandom_range(0, 256), $urandom, $urandom);
            else
                random_bar();
            count = $urandom_range(25, 60);
            for (int i = 0; i < count; i++)
            begin
                if (phase % 4 == 1 && i == count / 2)
                    wait_bar_idle();
                pixel_requests.push_back(pick_pixel());
            end
            total += count;
            phase++;
        end

        wait_bar_idle();
        repeat (LATENCY + 4) @(negedge clk);
        if (mismatch_count == 0)
            $display("dot_grid_bar_pixel_generator_test: clean");
        else
            $display("dot_grid_bar_pixel_generator_test: errors");
        $finish;
    end

    // Guard against a stalled run
    initial
    begin
        #(8 * 500000);
        $display("dot_grid_bar_pixel_generator_test: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/dgb_pkg.sv
sv/dot_grid_bar_pixel_generator.sv
sim/dot_grid_bar_pixel_generator_test.sv
